@@ hdl/gcid_pkg.sv @@
`default_nettype none
package gcid_pkg;
  localparam int NUM_LINES = 8;
  localparam int PIN_W = 8;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  localparam logic [6:0] OFF_OUT      = 7'h00;
  localparam logic [6:0] OFF_IN       = 7'h04;
  localparam logic [6:0] OFF_DIR      = 7'h08;
  localparam logic [6:0] OFF_SET      = 7'h10;
  localparam logic [6:0] OFF_CLR      = 7'h14;
  localparam logic [6:0] OFF_PULLEN   = 7'h18;
  localparam logic [6:0] OFF_PULLKIND = 7'h1C;
  localparam logic [6:0] OFF_IRQEN    = 7'h20;
  localparam logic [6:0] OFF_RAW      = 7'h24;
  localparam logic [6:0] OFF_MASKED   = 7'h28;
  localparam logic [6:0] OFF_MASK     = 7'h2C;
  localparam logic [6:0] OFF_IRQCLR   = 7'h30;
  localparam logic [6:0] OFF_EDGE     = 7'h34;
  localparam logic [6:0] OFF_BOTH     = 7'h38;
  localparam logic [6:0] OFF_POL      = 7'h3C;
  localparam logic [6:0] OFF_DBEN     = 7'h40;
  localparam logic [6:0] OFF_DIV      = 7'h44;

  typedef logic [NUM_LINES-1:0] line_t;

  // decoded item passed from front to back
  typedef struct packed {
    logic        is_read;
    logic        is_write;
    logic        is_tick;
    logic [6:0]  off;
    logic [31:0] wdata;
    logic [PIN_W-1:0] pins;
  } op_t;

  typedef struct packed {
    logic [31:0]      read_data;
    logic [PIN_W-1:0] pin_drive;
    logic [PIN_W-1:0] pin_enable;
    logic             irq_line;
  } res_t;
endpackage
`default_nettype wire

@@ hdl/gcid_if.sv @@
`default_nettype none
interface gcid_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [6:0]  reg_offset;
  logic [31:0] write_data;
  logic [7:0]  pin_levels;
  modport source (output valid, cmd, reg_offset, write_data, pin_levels, input ready);
  modport sink (input valid, cmd, reg_offset, write_data, pin_levels, output ready);
endinterface

interface gcid_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [7:0]  pin_drive;
  logic [7:0]  pin_enable;
  logic        irq_line;
  modport source (output valid, read_data, pin_drive, pin_enable, irq_line, input ready);
  modport sink (input valid, read_data, pin_drive, pin_enable, irq_line, output ready);
endinterface
`default_nettype wire

@@ hdl/gpio_controller_with_irq_detect_top.sv @@
// channel | dir | payload
// in_     | in  | cmd, reg_offset, write_data, pin_levels
// out_    | out | read_data, pin_drive, pin_enable, irq_line
// One item per cycle sustained while the receiver is ready. An accepted item is
// written into the queue, executed out of it into the output register, and
// offered as a result from there.
// Reset clears all registers but the queue storage; the queue empties.
// Output stall backs up the queue, then the input: with the receiver stalled the
// block holds three items (two queued, one in the output register) before
// in_ready drops.
`default_nettype none
module gpio_controller_with_irq_detect_top
  import gcid_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  gcid_in_if.sink   in_ch,
  gcid_out_if.source out_ch
);
  op_t  f_op, q_op;
  logic f_valid, f_ready, q_valid, q_ready;

  gcid_front u_front (.clk, .rst_n, .in_ch, .op(f_op), .op_valid(f_valid), .op_ready(f_ready));
  gcid_fifo u_fifo (.clk, .rst_n, .wr_op(f_op), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_op(q_op), .rd_valid(q_valid), .rd_ready(q_ready));
  gcid_back u_back (.clk, .rst_n, .op(q_op), .op_valid(q_valid), .op_ready(q_ready), .out_ch);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  a_rd0: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && q_ready && !q_op.is_read |=> out_ch.read_data == 32'd0)
    else $error("read_data not zero");
endmodule
`default_nettype wire

@@ hdl/gcid_front.sv @@
`default_nettype none
module gcid_front
  import gcid_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  gcid_in_if.sink   in_ch,
  output op_t       op,
  output logic      op_valid,
  input  wire logic op_ready
);
  cmd_t c;
  always_comb begin
    c = cmd_t'(in_ch.cmd);
    in_ch.ready = op_ready;
    op_valid = in_ch.valid;
    op.is_read = (c == CMD_READ);
    op.is_write = (c == CMD_WRITE);
    op.is_tick = (c == CMD_TICK);
    op.off = in_ch.reg_offset;
    op.wdata = in_ch.write_data;
    op.pins = in_ch.pin_levels;
  end
  logic unused_clk;
  assign unused_clk = clk ^ rst_n;
endmodule
`default_nettype wire

@@ hdl/gcid_fifo.sv @@
`default_nettype none
module gcid_fifo
  import gcid_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  op_t       wr_op,
  input  wire logic wr_valid,
  output logic      wr_ready,
  output op_t       rd_op,
  output logic      rd_valid,
  input  wire logic rd_ready
);
  // two-entry queue
  op_t        mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_op = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_op;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

@@ hdl/gcid_back.sv @@
`default_nettype none
module gcid_back
  import gcid_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  op_t       op,
  input  wire logic op_valid,
  output logic      op_ready,
  gcid_out_if.source out_ch
);
  line_t out_r, dir_r, pen_r, pkind_r, ien_r, raw_r, mask_r;
  line_t edge_r, both_r, pol_r, dben_r, filt_r, prev_r;
  logic [31:0] div_r, cnt_r;
  logic  ov_r;
  res_t  res_r;

  line_t out_nxt, raw_nxt, filt_nxt, m, sample, take, rise, fall, edge_ev, lvl_ev, ev;
  logic [31:0] rd, cnt_nxt;
  logic  strobe, go;

  assign op_ready = !ov_r || out_ch.ready;
  assign go = op_valid && op_ready;

  always_comb begin
    m = op.wdata[NUM_LINES-1:0];
    sample = line_t'(op.pins);
    strobe = cnt_r >= div_r;
    take = strobe ? '1 : ~dben_r;
    filt_nxt = (sample & take) | (filt_r & ~take);
    rise = filt_nxt & ~filt_r;
    fall = filt_r & ~filt_nxt;
    edge_ev = (both_r & (rise | fall)) | (~both_r & ((pol_r & rise) | (~pol_r & fall)));
    lvl_ev = (pol_r & filt_nxt) | (~pol_r & ~filt_nxt);
    ev = (edge_r & edge_ev) | (~edge_r & lvl_ev);
    cnt_nxt = strobe ? 32'd0 : cnt_r + 32'd1;
    rd = '0;
    case (op.off)
      OFF_OUT:      rd = 32'(out_r);
      OFF_IN:       rd = 32'(filt_r);
      OFF_DIR:      rd = 32'(dir_r);
      OFF_PULLEN:   rd = 32'(pen_r);
      OFF_PULLKIND: rd = 32'(pkind_r);
      OFF_IRQEN:    rd = 32'(ien_r);
      OFF_RAW:      rd = 32'(raw_r);
      OFF_MASKED:   rd = 32'(raw_r & ~mask_r);
      OFF_MASK:     rd = 32'(mask_r);
      OFF_EDGE:     rd = 32'(edge_r);
      OFF_BOTH:     rd = 32'(both_r);
      OFF_POL:      rd = 32'(pol_r);
      OFF_DBEN:     rd = 32'(dben_r);
      OFF_DIV:      rd = div_r;
      default:      rd = '0;
    endcase
    if (!op.is_read) rd = '0;
    out_nxt = out_r;
    raw_nxt = raw_r;
    if (op.is_write) begin
      case (op.off)
        OFF_OUT:    out_nxt = m;
        OFF_SET:    out_nxt = out_r | m;
        OFF_CLR:    out_nxt = out_r & ~m;
        OFF_IRQCLR: raw_nxt = raw_r & ~m;
        default:    ;
      endcase
    end
    if (op.is_tick) raw_nxt = raw_r | (ev & ien_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r <= '0; dir_r <= '0; pen_r <= '0; pkind_r <= '0; ien_r <= '0;
      raw_r <= '0; mask_r <= '0; edge_r <= '0; both_r <= '0; pol_r <= '0;
      dben_r <= '0; filt_r <= '0; prev_r <= '0; div_r <= '0; cnt_r <= '0;
      ov_r <= 1'b0;
      res_r <= '0;
    end else begin
      if (out_ch.ready) ov_r <= 1'b0;
      if (go) begin
        out_r <= out_nxt;
        raw_r <= raw_nxt;
        if (op.is_write) begin
          case (op.off)
            OFF_DIR:      dir_r <= m;
            OFF_PULLEN:   pen_r <= m;
            OFF_PULLKIND: pkind_r <= m;
            OFF_IRQEN:    ien_r <= m;
            OFF_MASK:     mask_r <= m;
            OFF_EDGE:     edge_r <= m;
            OFF_BOTH:     both_r <= m;
            OFF_POL:      pol_r <= m;
            OFF_DBEN:     dben_r <= m;
            OFF_DIV: begin
              div_r <= op.wdata;
              cnt_r <= '0;
            end
            default: ;
          endcase
        end
        if (op.is_tick) begin
          cnt_r <= cnt_nxt;
          prev_r <= filt_r;
          filt_r <= filt_nxt;
        end
        ov_r <= 1'b1;
        res_r.read_data <= rd;
        res_r.pin_drive <= PIN_W'(out_nxt);
        res_r.pin_enable <= PIN_W'((op.is_write && op.off == OFF_DIR) ? m : dir_r);
        res_r.irq_line <= |(raw_nxt &
                            ~((op.is_write && op.off == OFF_MASK) ? m : mask_r));
      end
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.read_data = res_r.read_data;
  assign out_ch.pin_drive = res_r.pin_drive;
  assign out_ch.pin_enable = res_r.pin_enable;
  assign out_ch.irq_line = res_r.irq_line;
endmodule
`default_nettype wire

@@ dv/gcid_checker.sv @@
`timescale 1ns / 100ps
module gcid_checker
  import gcid_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_ready,
  input  wire logic [1:0] in_cmd,
  input  wire logic [6:0] in_reg_offset,
  input  wire logic [31:0] in_write_data,
  input  wire logic [7:0] in_pin_levels,
  input  wire logic out_valid,
  input  wire logic out_ready,
  input  wire logic [31:0] out_read_data,
  input  wire logic [7:0] out_pin_drive,
  input  wire logic [7:0] out_pin_enable,
  input  wire logic out_irq_line,
  output int fail_count,
  output int pending
);
  line_t r_out, r_dir, r_pen, r_pkind, r_ien, r_raw, r_mask, r_edge, r_both, r_pol, r_dben;
  line_t r_filt, r_prev;
  logic [31:0] r_div, r_cnt;
  res_t gpio_results_q[$];

  function automatic logic [31:0] gpio_reg_value(logic [6:0] off);
    case (off)
      OFF_OUT:      return 32'(r_out);
      OFF_IN:       return 32'(r_filt);
      OFF_DIR:      return 32'(r_dir);
      OFF_PULLEN:   return 32'(r_pen);
      OFF_PULLKIND: return 32'(r_pkind);
      OFF_IRQEN:    return 32'(r_ien);
      OFF_RAW:      return 32'(r_raw);
      OFF_MASKED:   return 32'(r_raw & ~r_mask);
      OFF_MASK:     return 32'(r_mask);
      OFF_EDGE:     return 32'(r_edge);
      OFF_BOTH:     return 32'(r_both);
      OFF_POL:      return 32'(r_pol);
      OFF_DBEN:     return 32'(r_dben);
      OFF_DIV:      return r_div;
      default:      return 32'd0;
    endcase
  endfunction

  task automatic gpio_predict(logic [1:0] cmd, logic [6:0] off, logic [31:0] wd,
                              logic [7:0] pins);
    res_t r;
    line_t m, take, nw, old, rise, fall, eev, lev, ev;
    logic strobe;
    m = wd[NUM_LINES-1:0];
    r = '0;
    case (cmd)
      CMD_READ: r.read_data = gpio_reg_value(off);
      CMD_WRITE: begin
        case (off)
          OFF_OUT:      r_out = m;
          OFF_DIR:      r_dir = m;
          OFF_SET:      r_out |= m;
          OFF_CLR:      r_out &= ~m;
          OFF_PULLEN:   r_pen = m;
          OFF_PULLKIND: r_pkind = m;
          OFF_IRQEN:    r_ien = m;
          OFF_MASK:     r_mask = m;
          OFF_IRQCLR:   r_raw &= ~m;
          OFF_EDGE:     r_edge = m;
          OFF_BOTH:     r_both = m;
          OFF_POL:      r_pol = m;
          OFF_DBEN:     r_dben = m;
          OFF_DIV: begin
            r_div = wd;
            r_cnt = '0;
          end
          default: ;
        endcase
      end
      CMD_TICK: begin
        strobe = r_cnt >= r_div;
        r_cnt = strobe ? 32'd0 : r_cnt + 32'd1;
        old = r_filt;
        take = strobe ? '1 : ~r_dben;
        nw = (pins[NUM_LINES-1:0] & take) | (old & ~take);
        rise = nw & ~old;
        fall = old & ~nw;
        eev = (r_both & (rise | fall)) | (~r_both & ((r_pol & rise) | (~r_pol & fall)));
        lev = (r_pol & nw) | (~r_pol & ~nw);
        ev = (r_edge & eev) | (~r_edge & lev);
        r_raw |= ev & r_ien;
        r_prev = old;
        r_filt = nw;
      end
      default: ;
    endcase
    r.pin_drive = r_out;
    r.pin_enable = r_dir;
    r.irq_line = |(r_raw & ~r_mask);
    gpio_results_q.push_back(r);
  endtask

  always @(posedge clk) begin
    res_t e;
    if (!rst_n) begin
      {r_out, r_dir, r_pen, r_pkind, r_ien, r_raw, r_mask} = '0;
      {r_edge, r_both, r_pol, r_dben, r_filt, r_prev} = '0;
      r_div = '0;
      r_cnt = '0;
      fail_count = 0;
      gpio_results_q.delete();
      pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (gpio_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result item rd=%h", out_read_data);
        end else begin
          e = gpio_results_q.pop_front();
          if (e.read_data !== out_read_data || e.pin_drive !== out_pin_drive ||
              e.pin_enable !== out_pin_enable || e.irq_line !== out_irq_line) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch exp rd=%h drv=%h en=%h irq=%b got rd=%h drv=%h en=%h irq=%b",
                       e.read_data, e.pin_drive, e.pin_enable, e.irq_line, out_read_data,
                       out_pin_drive, out_pin_enable, out_irq_line);
          end
        end
      end
      if (in_valid && in_ready)
        gpio_predict(in_cmd, in_reg_offset, in_write_data, in_pin_levels);
      pending = gpio_results_q.size();
    end
  end
endmodule

@@ dv/tb_gpio_controller_with_irq_detect_top.sv @@
`timescale 1ns / 100ps
module tb_gpio_controller_with_irq_detect_top;
  import gcid_pkg::*;
  logic clk = 0;
  logic rst_n = 0;
  int fail_count, pending, cycles;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  logic stim_done = 0;

  gcid_in_if in_ch();
  gcid_out_if out_ch();

  always #2 clk = ~clk;

  gpio_controller_with_irq_detect_top u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  gcid_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cmd(in_ch.cmd),
    .in_reg_offset(in_ch.reg_offset), .in_write_data(in_ch.write_data),
    .in_pin_levels(in_ch.pin_levels),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_read_data(out_ch.read_data), .out_pin_drive(out_ch.pin_drive),
    .out_pin_enable(out_ch.pin_enable), .out_irq_line(out_ch.irq_line),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    in_ch.valid = 0;
    in_ch.cmd = CMD_NOP;
    in_ch.reg_offset = '0;
    in_ch.write_data = '0;
    in_ch.pin_levels = '0;
    out_ch.ready = 0;
  end

  // receiver stall pattern, plus a long hold-off counted here on request
  always @(posedge clk) begin
    int k;
    k = $urandom_range(0, 15);
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= 40;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (cycles % 64 < 20) ? 1'b1 : (k > 4);
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [6:0] off, logic [31:0] wd, logic [7:0] pins);
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.reg_offset <= off;
    in_ch.write_data <= wd;
    in_ch.pin_levels <= pins;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [6:0] pick_offset();
    int k;
    k = $urandom_range(0, 19);
    if (k < 18) return 7'(k * 4);
    if (k == 18) return 7'($urandom_range(0, 127));
    return 7'h7C;
  endfunction

  function automatic logic [31:0] pick_data();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(0, 4));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int n, burst;
    logic [1:0] c;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes and special cases
    send_item(CMD_WRITE, OFF_OUT, 32'hFFFF_FFFF, 8'h00);
    send_item(CMD_WRITE, OFF_DIR, 32'hFFFF_FF5A, 8'hFF);
    send_item(CMD_WRITE, OFF_CLR, 32'h0000_000F, 8'h00);
    send_item(CMD_WRITE, OFF_SET, 32'h0000_0001, 8'h00);
    send_item(CMD_READ, OFF_SET, 32'd0, 8'h00);
    send_item(CMD_READ, OFF_OUT, 32'd0, 8'h00);
    send_item(CMD_WRITE, OFF_IRQEN, 32'hFF, 8'h00);
    send_item(CMD_TICK, 7'h00, 32'd0, 8'h00);
    send_item(CMD_READ, OFF_RAW, 32'd0, 8'h00);
    send_item(CMD_WRITE, OFF_MASK, 32'h0F, 8'h00);
    send_item(CMD_READ, OFF_MASKED, 32'd0, 8'h00);
    send_item(CMD_WRITE, OFF_IRQCLR, 32'hFF, 8'h00);
    send_item(CMD_WRITE, OFF_EDGE, 32'hFF, 8'h00);
    send_item(CMD_WRITE, OFF_BOTH, 32'h33, 8'h00);
    send_item(CMD_WRITE, OFF_POL, 32'h0F, 8'h00);
    send_item(CMD_TICK, 7'h00, 32'd0, 8'hFF);
    send_item(CMD_WRITE, OFF_DBEN, 32'hF0, 8'h00);
    send_item(CMD_WRITE, OFF_DIV, 32'd2, 8'h00);
    send_item(CMD_TICK, 7'h00, 32'd0, 8'h00);
    send_item(CMD_TICK, 7'h00, 32'd0, 8'hA5);
    send_item(CMD_WRITE, OFF_IN, 32'hFF, 8'h00);
    send_item(CMD_WRITE, 7'h0C, 32'hFF, 8'h00);
    send_item(CMD_READ, 7'h0C, 32'd0, 8'h00);
    send_item(CMD_READ, 7'h46, 32'd0, 8'h00);
    send_item(CMD_NOP, OFF_OUT, 32'hFFFF_FFFF, 8'hFF);
    send_item(CMD_READ, OFF_DIV, 32'd0, 8'h00);
    wait_drained();
    n = 0;
    while (n < 500) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        case ($urandom_range(0, 9))
          0, 1, 2: c = CMD_READ;
          3, 4, 5: c = CMD_WRITE;
          9: c = CMD_NOP;
          default: c = CMD_TICK;
        endcase
        send_item(c, pick_offset(), pick_data(), 8'($urandom));
        n++;
      end
      if (n > 150 && n < 180) begin
        // long receiver hold-off while input keeps coming
        hold_req <= hold_req + 1;
        repeat (10) send_item(CMD_TICK, 7'h00, 32'd0, 8'($urandom));
        n += 10;
        idle_cycles(30);
      end
      if (n > 300 && n < 330) wait_drained();
      else idle_cycles($urandom_range(0, 6));
    end
    in_ch.valid <= 1'b0;
    stim_done <= 1'b1;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (stim_done && pending == 0) begin
        repeat (10) @(posedge clk);
        if (fail_count == 0) $display("[gpio_controller_with_irq_detect_top] OK");
        else $display("[gpio_controller_with_irq_detect_top] ERROR");
        $finish;
      end
      if (cycles > 200000) begin
        $display("[gpio_controller_with_irq_detect_top] ERROR");
        $finish;
      end
    end
  end
endmodule

@@ filelist.f @@
hdl/gcid_pkg.sv
hdl/gcid_if.sv
hdl/gcid_front.sv
hdl/gcid_fifo.sv
hdl/gcid_back.sv
hdl/gpio_controller_with_irq_detect_top.sv
dv/gcid_checker.sv
dv/tb_gpio_controller_with_irq_detect_top.sv
